### src/rav_pkg.sv
// Shared types and constants of the running average filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rav_pkg;

	localparam int DATA_W = 16;
	localparam int CFG_W  = 6;

	typedef logic [DATA_W-1:0] sample_t;
	typedef logic [CFG_W-1:0]  win_t;

	localparam win_t WIN_RESET = win_t'(20);

endpackage

### src/rav_mem.sv
// Sample ring store: one write port, one read port, registered read data.
// Depends on rav_pkg for the sample type.
`timescale 1ns / 1ps

module rav_mem #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  rav_pkg::sample_t    wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output rav_pkg::sample_t    rd_data
);

	rav_pkg::sample_t mem [DEPTH];
	rav_pkg::sample_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/rav_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rav_pkg for the divisor width.
`timescale 1ns / 1ps

module rav_div #(
	parameter int DVD_W = 22
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [DVD_W-1:0]        dividend,
	input  rav_pkg::win_t           divisor,
	output logic                    busy,
	output logic [DVD_W-1:0]        quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);
	localparam int REM_W = rav_pkg::CFG_W + 1;

	logic [DVD_W-1:0] dvd_q;
	logic [REM_W-1:0] rem_q;
	rav_pkg::win_t    dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [REM_W-1:0] rem_sh;
	logic             fits;

	assign rem_sh = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? rem_sh - {1'b0, dsr_q} : rem_sh;
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule

### src/running_average_filter.sv
// Top level of the running average filter: control, running sum, output item.
// Depends on rav_pkg, rav_mem and rav_div.
//
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    s_tdata[15:0] sample
// m_*      out  m_tvalid / m_tready    m_tdata[15:0] average
// cfg_*    in   cfg_valid / cfg_ready  cfg_data[5:0] window_size
//
// An accepted item passes through the store read, the bit-serial divider and the load
// of the output register, in that order; m_tvalid rises with that load, and the next
// item is taken only after it, so one item is in flight at a time.
// Reset sets window_size to 20 and empties the history; the store is not swept,
// slots beyond the fill count read as zero.
// A stalled output holds the divider result until m_tready rises.
`timescale 1ns / 1ps

module running_average_filter #(
	parameter int MAX_WINDOW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [15:0] sample
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [15:0] average
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [5:0]           cfg_data   // [5:0] window_size
);

	localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUM_W  = rav_pkg::DATA_W + $clog2(MAX_WINDOW + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	logic [1:0]          state_q;
	rav_pkg::win_t       win_q;
	rav_pkg::win_t       seen_q;
	logic [ADDR_W-1:0]   slot_q;
	logic [SUM_W-1:0]    sum_q;
	logic [ADDR_W-1:0]   slot_s1;
	rav_pkg::sample_t    sample_s1;
	logic                m_tvalid_q;
	rav_pkg::sample_t    m_tdata_q;

	rav_pkg::win_t       win_eff;
	logic [ADDR_W-1:0]   slot_cur;
	logic [ADDR_W:0]     slot_inc;
	logic [ADDR_W-1:0]   slot_next;
	rav_pkg::win_t       seen_next;
	rav_pkg::sample_t    rd_data;
	rav_pkg::sample_t    old_val;
	logic [SUM_W-1:0]    sum_next;
	logic                s_acc;
	logic                cfg_acc;
	logic                div_start;
	logic                div_busy;
	logic [SUM_W-1:0]    div_quot;
	logic                out_free;
	logic                out_load;

	always_comb begin
		if (win_q == '0) begin
			win_eff = rav_pkg::win_t'(1);
		end else if (32'(win_q) > MAX_WINDOW) begin
			win_eff = rav_pkg::win_t'(MAX_WINDOW);
		end else begin
			win_eff = win_q;
		end
	end

	assign slot_cur  = (32'(slot_q) >= 32'(win_eff)) ? '0 : slot_q;
	assign slot_inc  = {1'b0, slot_s1} + 1'b1;
	assign slot_next = (32'(slot_inc) >= 32'(win_eff)) ? '0 : slot_inc[ADDR_W-1:0];
	assign seen_next = (seen_q < win_eff) ? seen_q + 1'b1 : seen_q;
	assign old_val   = (seen_q < win_eff) ? '0 : rd_data;
	assign sum_next  = sum_q - SUM_W'(old_val) + SUM_W'(sample_s1);

	assign cfg_ready = state_q == ST_IDLE;
	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign div_start = state_q == ST_READ;
	assign out_free  = !m_tvalid_q || m_tready;
	assign out_load  = (state_q == ST_DIV) && !div_busy && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			win_q      <= rav_pkg::WIN_RESET;
			seen_q     <= '0;
			slot_q     <= '0;
			sum_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						win_q  <= cfg_data;
						seen_q <= '0;
						slot_q <= '0;
						sum_q  <= '0;
					end else if (s_acc) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					sum_q   <= sum_next;
					seen_q  <= seen_next;
					slot_q  <= slot_next;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			slot_s1   <= slot_cur;
			sample_s1 <= s_tdata;
		end
		if (out_load) begin
			m_tdata_q <= div_quot[rav_pkg::DATA_W-1:0];
		end
	end

	rav_mem #(
		.DEPTH  (MAX_WINDOW),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (state_q == ST_READ),
		.wr_addr (slot_s1),
		.wr_data (sample_s1),
		.rd_en   (s_acc),
		.rd_addr (slot_cur),
		.rd_data (rd_data)
	);

	rav_div #(
		.DVD_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (seen_next),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_acc_reads: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> state_q == ST_READ)
		else $error("accepted item did not start a store read");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= win_eff)
		else $error("fill count exceeds window");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(slot_q) < 32'(win_eff))
		else $error("ring slot outside window");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> seen_q == '0 && slot_q == '0 && sum_q == '0)
		else $error("window write did not clear history");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !div_busy)
		else $error("divider busy at start of a new item");

endmodule
